@@ rtl/mmp_pkg.sv @@
`default_nettype none
package mmp_pkg;

	localparam int MaxDim = 8;
	localparam int IdxW = $clog2(MaxDim);
	localparam int DimW = IdxW + 1;
	localparam int ValW = 30;
	localparam int ExpW = 63;
	localparam int SeqW = 2 * IdxW;

	localparam logic [ValW-1:0] Prime = 30'd1000000007;
	// Barrett constant floor(2^60 / Prime)
	localparam logic [30:0] BarrettMu = 31'((64'd1 << 60) / 64'(Prime));

	typedef logic [ValW-1:0] val_t;

	typedef struct packed {
		logic            init;
		logic            ld_a;
		logic [IdxW-1:0] ld_row;
		logic            shift;
		logic            issue;
		logic [IdxW-1:0] step;
		logic [IdxW-1:0] mrow;
		logic            use_base;
		logic [DimW-1:0] dim;
		logic            commit;
		logic            bwr;
		logic [IdxW-1:0] brow;
		logic [IdxW-1:0] bcol;
		val_t            bval;
		logic [IdxW-1:0] rd_row;
	} cell_ctrl_t;

	function automatic val_t mod_add(input val_t a, input val_t b);
		logic [ValW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, Prime}) s = s - {1'b0, Prime};
		return s[ValW-1:0];
	endfunction

	function automatic val_t mod_fix(input val_t a);
		return (a >= Prime) ? a - Prime : a;
	endfunction

endpackage
`default_nettype wire

@@ rtl/mmp_if.sv @@
`default_nettype none
interface mmp_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [2:0]  row;
	logic [2:0]  col;
	logic [29:0] entry_value;
	logic [62:0] exponent;

	modport source(output valid, opcode, row, col, entry_value, exponent, input ready);
	modport sink(input valid, opcode, row, col, entry_value, exponent, output ready);
endinterface

interface mmp_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_row;
	logic [2:0]  out_col;
	logic [29:0] out_value;
	logic        last;

	modport source(output valid, out_row, out_col, out_value, last, input ready);
	modport sink(input valid, out_row, out_col, out_value, last, output ready);
endinterface
`default_nettype wire

@@ rtl/modular_matrix_power_top.sv @@
`default_nettype none
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   opcode, row, col, entry_value, exponent
// rsp      out  valid/ready   out_row, out_col, out_value, last
// cfg      in   cfg_we        cfg_data = matrix_dim
//
// A run does one squaring per exponent bit (64) plus one product per set bit, each on
// the 8-cell multiply chain. Then d*d items, one per cycle unstalled.
// No clearing pass after reset. req is held off during a run and while entries are sent;
// a stalled rsp holds the output register and the sequencer.
module modular_matrix_power_top
	import mmp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_data,
	mmp_req_if.sink         req,
	mmp_rsp_if.source       rsp
);

	typedef enum logic [1:0] {S_IDLE, S_PREP, S_MUL, S_OUT} state_t;

	localparam logic [SeqW:0] CntEnd = (SeqW + 1)'(MaxDim * MaxDim + 7);

	state_t          state_q;
	logic [SeqW:0]   cnt_q;
	logic [5:0]      bit_q;
	logic            sqr_q;
	logic [63:0]     exp_q;
	logic [IdxW-1:0] oi_q, oj_q;
	logic [3:0]      dim_q;
	logic            ov_q;
	logic [2:0]      orow_q, ocol_q;
	val_t            oval_q;
	logic            olast_q;

	logic [DimW-1:0] d;
	logic [IdxW-1:0] dm1;
	logic            acc_in, issuing, out_load, out_last;
	cell_ctrl_t      ctl;
	val_t            a_ring [MaxDim];
	val_t            rd_col [MaxDim];

	assign d = (dim_q == 4'd0) ? DimW'(1) :
		(dim_q > 4'(MaxDim)) ? DimW'(MaxDim) : DimW'(dim_q);
	assign dm1 = IdxW'(d - DimW'(1));

	assign req.ready = state_q == S_IDLE;
	assign acc_in = req.valid && req.ready;
	assign issuing = state_q == S_MUL && !cnt_q[SeqW];
	assign out_load = state_q == S_OUT && (!ov_q || rsp.ready);
	assign out_last = oi_q == dm1 && oj_q == dm1;

	always_comb begin
		ctl.init     = acc_in && req.opcode;
		ctl.ld_a     = state_q == S_PREP || (issuing && cnt_q[IdxW-1:0] == IdxW'(MaxDim - 1));
		ctl.ld_row   = (state_q == S_PREP) ? '0 : cnt_q[SeqW-1:IdxW] + IdxW'(1);
		ctl.shift    = issuing;
		ctl.issue    = issuing;
		ctl.step     = cnt_q[IdxW-1:0];
		ctl.mrow     = cnt_q[SeqW-1:IdxW];
		ctl.use_base = !sqr_q;
		ctl.dim      = d;
		ctl.commit   = state_q == S_MUL && cnt_q == CntEnd;
		ctl.bwr      = acc_in && !req.opcode;
		ctl.brow     = req.row;
		ctl.bcol     = req.col;
		ctl.bval     = mod_fix(req.entry_value);
		ctl.rd_row   = oi_q;
	end

	for (genvar j = 0; j < MaxDim; j++) begin : g_cell
		mmp_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.col_idx (IdxW'(j)),
			.ctl     (ctl),
			.a_in    (a_ring[(j + 1) % MaxDim]),
			.a_out   (a_ring[j]),
			.rd_data (rd_col[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			bit_q   <= '0;
			sqr_q   <= 1'b1;
			exp_q   <= '0;
			oi_q    <= '0;
			oj_q    <= '0;
			dim_q   <= 4'd2;
			ov_q    <= 1'b0;
			orow_q  <= '0;
			ocol_q  <= '0;
			oval_q  <= '0;
			olast_q <= 1'b0;
		end else begin
			if (cfg_we) dim_q <= cfg_data;
			if (out_load) ov_q <= 1'b1;
			else if (rsp.valid && rsp.ready) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (ctl.init) begin
						exp_q   <= {1'b0, req.exponent};
						bit_q   <= 6'd63;
						sqr_q   <= 1'b1;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CntEnd) begin
						if (sqr_q && exp_q[bit_q]) begin
							sqr_q   <= 1'b0;
							state_q <= S_PREP;
						end else if (bit_q == '0) begin
							oi_q    <= '0;
							oj_q    <= '0;
							state_q <= S_OUT;
						end else begin
							bit_q   <= bit_q - 1'b1;
							sqr_q   <= 1'b1;
							state_q <= S_PREP;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						orow_q  <= oi_q;
						ocol_q  <= oj_q;
						oval_q  <= rd_col[oj_q];
						olast_q <= out_last;
						if (out_last) begin
							state_q <= S_IDLE;
						end else if (oj_q == dm1) begin
							oj_q <= '0;
							oi_q <= oi_q + 1'b1;
						end else begin
							oj_q <= oj_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid     = ov_q;
	assign rsp.out_row   = orow_q;
	assign rsp.out_col   = ocol_q;
	assign rsp.out_value = oval_q;
	assign rsp.last      = olast_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MUL |-> cnt_q <= CntEnd)
		else $error("product counter overran");
	a_mul_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> state_q == S_PREP || state_q == S_OUT)
		else $error("bad step after product");
	a_out_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && out_last |=> state_q == S_IDLE && ov_q && rsp.last)
		else $error("last entry not closing the run");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.issue |-> !ctl.bwr && !ctl.init)
		else $error("item taken during a product");

endmodule
`default_nettype wire

@@ rtl/mmp_cell.sv @@
`default_nettype none
module mmp_cell
	import mmp_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [IdxW-1:0] col_idx,
	input  wire cell_ctrl_t      ctl,
	input  wire val_t            a_in,
	output val_t                 a_out,
	output val_t                 rd_data
);

	val_t base_q [MaxDim];
	val_t acc_q  [MaxDim];
	val_t scr_q  [MaxDim];
	val_t a_q;
	val_t sum_q;

	logic [IdxW-1:0] k;
	val_t b;

	logic            v_s1, v_s2, v_s3, v_s4;
	logic            first_s1, first_s2, first_s3, first_s4;
	logic            last_s1, last_s2, last_s3, last_s4;
	logic            zero_s1, zero_s2, zero_s3, zero_s4;
	logic [IdxW-1:0] row_s1, row_s2, row_s3, row_s4;
	logic [59:0]     prod_s1, prod_s2;
	logic [29:0]     q_s2;
	logic [31:0]     r_s3;
	val_t            r_s4;

	logic [61:0] qfull;
	logic [59:0] qp;
	logic [31:0] rr;
	val_t        sum;

	assign k = col_idx + ctl.step;
	assign b = ctl.use_base ? base_q[k] : acc_q[k];
	assign a_out = a_q;
	assign rd_data = acc_q[ctl.rd_row];

	assign qfull = 62'(prod_s1[59:29]) * 62'(BarrettMu);
	assign qp = 60'(q_s2) * 60'(Prime);
	assign sum = first_s4 ? r_s4 : mod_add(sum_q, r_s4);

	always_comb begin
		rr = r_s3;
		if (rr >= 32'(2 * 64'(Prime))) rr = rr - 32'(2 * 64'(Prime));
		else if (rr >= 32'(Prime)) rr = rr - 32'(Prime);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxDim; i++) base_q[i] <= '0;
		end else if (ctl.bwr && ctl.bcol == col_idx) begin
			base_q[ctl.brow] <= ctl.bval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_a) a_q <= acc_q[ctl.ld_row];
		else if (ctl.shift) a_q <= a_in;

		if (ctl.init) begin
			for (int i = 0; i < MaxDim; i++)
				acc_q[i] <= (IdxW'(i) == col_idx && DimW'(i) < ctl.dim) ? val_t'(1) : '0;
		end else if (ctl.commit) begin
			for (int i = 0; i < MaxDim; i++) acc_q[i] <= scr_q[i];
		end

		prod_s1  <= 60'(a_q) * 60'(b);
		first_s1 <= ctl.step == '0;
		last_s1  <= ctl.step == IdxW'(MaxDim - 1);
		row_s1   <= ctl.mrow;
		zero_s1  <= (DimW'(ctl.mrow) >= ctl.dim) || (DimW'(col_idx) >= ctl.dim);

		prod_s2  <= prod_s1;
		q_s2     <= qfull[60:31];
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		row_s2   <= row_s1;
		zero_s2  <= zero_s1;

		r_s3     <= prod_s2[31:0] - qp[31:0];
		first_s3 <= first_s2;
		last_s3  <= last_s2;
		row_s3   <= row_s2;
		zero_s3  <= zero_s2;

		r_s4     <= rr[29:0];
		first_s4 <= first_s3;
		last_s4  <= last_s3;
		row_s4   <= row_s3;
		zero_s4  <= zero_s3;

		if (v_s4) sum_q <= sum;
		if (v_s4 && last_s4) scr_q[row_s4] <= zero_s4 ? '0 : sum;
	end

endmodule
`default_nettype wire
